### sv/assert_macros.svh
// assertion helpers used by the bdau checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent implication on the same clock edge
`define CHK_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication on the next clock edge
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/bdau_pkg.sv
`default_nettype none
package bdau_pkg;

  localparam int VALUE_W    = 63;
  localparam int MAX_DIGITS = 19;
  localparam int DIGIT_W    = 4;
  localparam int CHAR_W     = 6;
  localparam int BIT_CNT_W  = $clog2(VALUE_W);
  localparam int REM_W      = $clog2(MAX_DIGITS + 1);

  localparam logic [BIT_CNT_W-1:0] LAST_BIT   = BIT_CNT_W'(VALUE_W - 1);
  localparam logic [REM_W-1:0]     REM_FULL   = REM_W'(MAX_DIGITS);
  localparam logic [REM_W-1:0]     REM_ONE    = REM_W'(1);
  localparam logic [DIGIT_W-1:0]   DABBLE_MIN = DIGIT_W'(5);
  localparam logic [DIGIT_W-1:0]   DABBLE_ADD = DIGIT_W'(3);
  localparam logic [CHAR_W-1:0]    ASCII_ZERO = CHAR_W'(48);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_DABBLE,
    CELL_SHIFT
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t cell_mode;
    logic       load_value;
    logic       shift_value;
    logic       emit;
    logic       last;
  } ctrl_t;

endpackage
`default_nettype wire

### sv/bdau_cell.sv
`default_nettype none
module bdau_cell (
  input  wire logic                       clk,
  input  wire bdau_pkg::cell_mode_t       mode,
  input  wire logic                       bit_in,
  input  wire logic [bdau_pkg::DIGIT_W-1:0] digit_in,
  output logic                            bit_out,
  output logic [bdau_pkg::DIGIT_W-1:0]    digit
);

  logic [bdau_pkg::DIGIT_W-1:0] adj;

  // add three before the shift so the digit stays decimal
  always_comb begin
    adj     = (digit >= bdau_pkg::DABBLE_MIN) ? digit + bdau_pkg::DABBLE_ADD : digit;
    bit_out = adj[bdau_pkg::DIGIT_W-1];
  end

  always_ff @(posedge clk) begin
    case (mode)
      bdau_pkg::CELL_CLEAR:  digit <= '0;
      bdau_pkg::CELL_DABBLE: digit <= {adj[bdau_pkg::DIGIT_W-2:0], bit_in};
      bdau_pkg::CELL_SHIFT:  digit <= digit_in;
      default:               digit <= digit;
    endcase
  end

endmodule
`default_nettype wire

### sv/bdau_ctrl.sv
`default_nettype none
module bdau_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic            top_zero,
  output logic                 busy,
  output bdau_pkg::ctrl_t      ctrl
);

  bdau_pkg::state_t                 state, state_next;
  logic [bdau_pkg::BIT_CNT_W-1:0]   bit_cnt;
  logic [bdau_pkg::REM_W-1:0]       rem;
  logic                             leading;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bdau_pkg::ST_IDLE: if (start) state_next = bdau_pkg::ST_CONV;
      bdau_pkg::ST_CONV: if (bit_cnt == bdau_pkg::LAST_BIT) state_next = bdau_pkg::ST_EMIT;
      bdau_pkg::ST_EMIT: if (rem == bdau_pkg::REM_ONE) state_next = bdau_pkg::ST_IDLE;
      default:           state_next = bdau_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy             = 1'b0;
    ctrl.cell_mode   = bdau_pkg::CELL_HOLD;
    ctrl.load_value  = 1'b0;
    ctrl.shift_value = 1'b0;
    ctrl.emit        = 1'b0;
    ctrl.last        = 1'b0;
    unique case (state)
      bdau_pkg::ST_IDLE: begin
        if (start) begin
          ctrl.cell_mode  = bdau_pkg::CELL_CLEAR;
          ctrl.load_value = 1'b1;
        end
      end
      bdau_pkg::ST_CONV: begin
        busy             = 1'b1;
        ctrl.cell_mode   = bdau_pkg::CELL_DABBLE;
        ctrl.shift_value = 1'b1;
      end
      bdau_pkg::ST_EMIT: begin
        busy           = 1'b1;
        ctrl.cell_mode = bdau_pkg::CELL_SHIFT;
        // leading zeros are shifted out silently, the final digit always goes
        ctrl.emit      = !(leading && top_zero && (rem != bdau_pkg::REM_ONE));
        ctrl.last      = (rem == bdau_pkg::REM_ONE);
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bdau_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bdau_pkg::ST_IDLE) begin
      bit_cnt <= '0;
      rem     <= bdau_pkg::REM_FULL;
      leading <= 1'b1;
    end else if (state == bdau_pkg::ST_CONV) begin
      bit_cnt <= bit_cnt + 1'b1;
    end else begin
      rem <= rem - 1'b1;
      if (ctrl.emit) begin
        leading <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### sv/binary_to_decimal_ascii_unit.sv
`default_nettype none
// conversion: the request is loaded in idle, then 63 bit-serial add-three steps fill the
//   digit chain and 19 shift steps move it out, top digit first, leading zeros unstrobed
// a new request is taken only once control is back in idle, after the last digit has
//   been shifted out of the digit chain
// reset: rst is synchronous, active high; control returns to idle, no strobe
// the receiver cannot stall: each digit is shown for exactly one cycle
module binary_to_decimal_ascii_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [bdau_pkg::VALUE_W-1:0]  value,
  output logic                               strobe,
  output logic [bdau_pkg::CHAR_W-1:0]        digit_char,
  output logic                               last_digit
);

  bdau_pkg::ctrl_t                ctrl;

  // binary operand, shifted out msb first into the lowest decimal cell
  logic [bdau_pkg::VALUE_W-1:0]   value_reg;

  // one bcd digit per cell, cell 0 least significant
  logic [bdau_pkg::DIGIT_W-1:0]   digit [bdau_pkg::MAX_DIGITS];
  logic                           carry [bdau_pkg::MAX_DIGITS];
  logic [bdau_pkg::DIGIT_W-1:0]   top_digit;

  assign top_digit = digit[bdau_pkg::MAX_DIGITS-1];

  bdau_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .top_zero (top_digit == '0),
    .busy     (busy),
    .ctrl     (ctrl)
  );

  always_ff @(posedge clk) begin
    if (ctrl.load_value) begin
      value_reg <= value;
    end else if (ctrl.shift_value) begin
      value_reg <= {value_reg[bdau_pkg::VALUE_W-2:0], 1'b0};
    end
  end

  // chain of digit cells: during conversion each cell hands its carry bit upwards,
  // during output each cell hands its digit upwards so the top cell is always next;
  // a carry out of the top cell is dropped, keeping only the low digits
  for (genvar i = 0; i < bdau_pkg::MAX_DIGITS; i++) begin : g_cell
    if (i == 0) begin : g_first
      bdau_cell u_cell (
        .clk      (clk),
        .mode     (ctrl.cell_mode),
        .bit_in   (value_reg[bdau_pkg::VALUE_W-1]),
        .digit_in ('0),
        .bit_out  (carry[i]),
        .digit    (digit[i])
      );
    end else begin : g_rest
      bdau_cell u_cell (
        .clk      (clk),
        .mode     (ctrl.cell_mode),
        .bit_in   (carry[i-1]),
        .digit_in (digit[i-1]),
        .bit_out  (carry[i]),
        .digit    (digit[i])
      );
    end
  end

  // registered result: one strobe cycle per digit
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctrl.emit;
    end
  end

  always_ff @(posedge clk) begin
    digit_char <= bdau_pkg::ASCII_ZERO + {{(bdau_pkg::CHAR_W-bdau_pkg::DIGIT_W){1'b0}}, top_digit};
    last_digit <= ctrl.last;
  end

endmodule
`default_nettype wire

### sv/bdau_checker.sv
`default_nettype none
`include "assert_macros.svh"
module bdau_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          strobe,
  input wire logic [bdau_pkg::CHAR_W-1:0]   digit_char,
  input wire logic                          last_digit
);

  `CHK_SAME(a_digit_range, clk, rst, strobe, (digit_char >= 6'd48) && (digit_char <= 6'd57), "digit out of range")
  `CHK_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "request not taken up")
  `CHK_SAME(a_mid_busy, clk, rst, strobe && !last_digit, busy, "idle before last digit")
  `CHK_NEXT(a_digits_run, clk, rst, strobe && !last_digit, strobe, "gap between digits")

endmodule

bind binary_to_decimal_ascii_unit bdau_checker u_bdau_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .strobe     (strobe),
  .digit_char (digit_char),
  .last_digit (last_digit)
);
`default_nettype wire

### bench/bdau_digit_checker.sv
`timescale 1ns / 100ps
module bdau_digit_checker
  import bdau_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic [VALUE_W-1:0]   value,
  input  logic                 strobe,
  input  logic [CHAR_W-1:0]    digit_char,
  input  logic                 last_digit,
  output int unsigned          mismatch_count,
  output int unsigned          pending_digits,
  output int unsigned          requests_seen,
  output int unsigned          digits_seen,
  output logic [MAX_DIGITS:1]  lengths_seen
);

  localparam int unsigned RADIX = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } digit_t;

  digit_t      expected_digits [$];
  int unsigned errors;

  // decimal digits of one number, queued most significant first; returns the digit count
  function automatic int queue_decimal_digits(input logic [VALUE_W-1:0] number);
    logic [3:0]         digit_buf [MAX_DIGITS];
    logic [VALUE_W-1:0] rest;
    digit_t             entry;
    int                 count;
    rest  = number;
    count = 0;
    do begin
      digit_buf[count] = 4'(rest % RADIX);
      rest             = rest / RADIX;
      count++;
    end while (rest != '0 && count < MAX_DIGITS);
    for (int k = count - 1; k >= 0; k--) begin
      entry.code = ASCII_ZERO + CHAR_W'(digit_buf[k]);
      entry.last = (k == 0);
      expected_digits.push_back(entry);
    end
    return count;
  endfunction

  always @(posedge clk) begin
    digit_t want;
    int     n;
    if (rst) begin
      expected_digits.delete();
      errors = 0;
      mismatch_count <= 0;
      pending_digits <= 0;
      requests_seen  <= 0;
      digits_seen    <= 0;
      lengths_seen   <= '0;
    end else begin
      // results first, so a digit can never match a request taken at the same edge
      if (strobe) begin
        if (expected_digits.size() == 0) begin
          $display("%0t: digit strobe with nothing expected, char %0d last %0b",
                   $time, digit_char, last_digit);
          errors++;
        end else begin
          want = expected_digits.pop_front();
          if (digit_char !== want.code) begin
            $display("%0t: digit_char expected %0d, actual %0d", $time, want.code, digit_char);
            errors++;
          end
          if (last_digit !== want.last) begin
            $display("%0t: last_digit expected %0b, actual %0b", $time, want.last, last_digit);
            errors++;
          end
        end
        digits_seen <= digits_seen + 1;
      end
      if (start && !busy) begin
        n = queue_decimal_digits(value);
        lengths_seen[n] <= 1'b1;
        requests_seen   <= requests_seen + 1;
      end
      mismatch_count <= errors;
      pending_digits <= expected_digits.size();
    end
  end

endmodule

### bench/binary_to_decimal_ascii_unit_test.sv
`timescale 1ns / 100ps
module binary_to_decimal_ascii_unit_test;
  import bdau_pkg::*;

  // the drain wait outlasts a full conversion and the cycle limit covers the whole run
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned RANDOM_ITEMS = 120;
  // random requests in this window are sent back to back with no pauses
  localparam int unsigned QUIET_FIRST  = 40;
  localparam int unsigned QUIET_LAST   = 79;

  logic               clk   = 1'b0;
  logic               rst   = 1'b1;
  logic               start = 1'b0;
  logic [VALUE_W-1:0] value = '0;
  logic               busy;
  logic               strobe;
  logic [CHAR_W-1:0]  digit_char;
  logic               last_digit;

  int unsigned         mismatch_count;
  int unsigned         pending_digits;
  int unsigned         requests_seen;
  int unsigned         digits_seen;
  logic [MAX_DIGITS:1] lengths_seen;
  int unsigned         cycle_count = 0;

  logic [VALUE_W-1:0] directed_values [$];

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  binary_to_decimal_ascii_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value      (value),
    .strobe     (strobe),
    .digit_char (digit_char),
    .last_digit (last_digit)
  );

  // watches both channels, predicts the digit string of every request and compares
  bdau_digit_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .value          (value),
    .strobe         (strobe),
    .digit_char     (digit_char),
    .last_digit     (last_digit),
    .mismatch_count (mismatch_count),
    .pending_digits (pending_digits),
    .requests_seen  (requests_seen),
    .digits_seen    (digits_seen),
    .lengths_seen   (lengths_seen)
  );

  function automatic logic [VALUE_W-1:0] power_of_ten(input int exponent);
    logic [VALUE_W-1:0] acc;
    acc = 1;
    repeat (exponent) acc = acc * 10;
    return acc;
  endfunction

  // present one request and hold it until the block takes it; an optional pause
  // beforehand drops start, which lands on any phase of the conversion in flight
  // since the pause can be shorter or longer than the busy window
  task automatic issue_request(input logic [VALUE_W-1:0] number, input bit may_pause);
    int unsigned pause;
    pause = 0;
    if (may_pause && $urandom_range(0, 99) < 8) pause = $urandom_range(1, 100);
    if (pause != 0) begin
      start <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    start <= 1'b1;
    value <= number;
    // busy read here is the value before this edge, i.e. what the block saw
    do begin
      @(posedge clk);
    end while (busy);
  endtask

  // random number with a spread of decimal lengths, weighted towards the digit
  // boundaries where carries out of the top digit are most likely to go wrong
  function automatic logic [VALUE_W-1:0] random_number();
    logic [VALUE_W-1:0] raw;
    int unsigned        pick;
    int unsigned        nbits;
    raw  = VALUE_W'({$urandom, $urandom});
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      nbits = $urandom_range(1, VALUE_W);
      return raw >> (VALUE_W - nbits);
    end else if (pick < 8) begin
      return power_of_ten($urandom_range(1, 18)) - 2 + VALUE_W'($urandom_range(0, 4));
    end else begin
      return raw;
    end
  endfunction

  // cycle limit guards against a hung handshake or a missing last digit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d digits still expected", $time, pending_digits);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    // zero, single digits, the digit-count boundaries at 10, 100, 10^17 and 10^18, both
    // extremes of the field and alternating bit patterns so each value bit is seen at 0 and 1
    directed_values.push_back('0);
    directed_values.push_back(VALUE_W'(1));
    directed_values.push_back(VALUE_W'(9));
    directed_values.push_back(VALUE_W'(10));
    directed_values.push_back(VALUE_W'(99));
    directed_values.push_back(VALUE_W'(100));
    directed_values.push_back(VALUE_W'(12345));
    directed_values.push_back(VALUE_W'(1_000_000_007));
    directed_values.push_back(power_of_ten(17));
    directed_values.push_back(power_of_ten(18) - 1);
    directed_values.push_back(power_of_ten(18));
    directed_values.push_back(power_of_ten(18) + 1);
    directed_values.push_back(VALUE_W'(1) << (VALUE_W - 1));
    directed_values.push_back(63'h2AAA_AAAA_AAAA_AAAA);
    directed_values.push_back(63'h5555_5555_5555_5555);
    directed_values.push_back({VALUE_W{1'b1}});
    directed_values.push_back('0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_values[i]) issue_request(directed_values[i], 1'b1);

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      issue_request(random_number(), !(n >= QUIET_FIRST && n <= QUIET_LAST));
    end
    start <= 1'b0;

    // let the last request show up in the pending count, then drain
    @(posedge clk);
    while (pending_digits != 0) @(posedge clk);
    // catch any stray strobes after the last expected digit
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("converted %0d requests, %0d digit strobes compared",
             requests_seen, digits_seen);
    $display("number lengths exercised: %0d of %0d digit counts",
             $countones(lengths_seen), MAX_DIGITS);
    if (mismatch_count == 0 && pending_digits == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/bdau_pkg.sv
sv/bdau_cell.sv
sv/bdau_ctrl.sv
sv/binary_to_decimal_ascii_unit.sv
sv/bdau_checker.sv
bench/bdau_digit_checker.sv
bench/binary_to_decimal_ascii_unit_test.sv
